// ===== rtl/core/zalu_pkg.sv =====
// Package for the Z-machine ALU: opcodes, widths and the divider cell payload.
// No dependencies.
package zalu_pkg;
  localparam int WordW = 16;
  localparam int OpW = 4;
  localparam logic [OpW-1:0] OP_INC = 4'd0;
  localparam logic [OpW-1:0] OP_DEC = 4'd1;
  localparam logic [OpW-1:0] OP_NOT = 4'd2;
  localparam logic [OpW-1:0] OP_DEC_CHK = 4'd3;
  localparam logic [OpW-1:0] OP_INC_CHK = 4'd4;
  localparam logic [OpW-1:0] OP_TEST = 4'd5;
  localparam logic [OpW-1:0] OP_OR = 4'd6;
  localparam logic [OpW-1:0] OP_AND = 4'd7;
  localparam logic [OpW-1:0] OP_ADD = 4'd8;
  localparam logic [OpW-1:0] OP_SUB = 4'd9;
  localparam logic [OpW-1:0] OP_MUL = 4'd10;
  localparam logic [OpW-1:0] OP_DIV = 4'd11;
  localparam logic [OpW-1:0] OP_MOD = 4'd12;
  localparam logic [OpW-1:0] OP_LSHIFT = 4'd13;
  localparam logic [OpW-1:0] OP_ASHIFT = 4'd14;

  typedef struct packed {
    logic             valid;
    logic [OpW-1:0]   op;
    logic [WordW-1:0] res;
    logic             store;
    logic             br;
    logic             derr;
    logic             qneg;
    logic             rneg;
    logic [WordW-1:0] rem;
    logic [WordW-1:0] quo;
    logic [WordW-1:0] dvs;
  } zalu_cell_t;
endpackage

// ===== rtl/core/zalu_front.sv =====
// Front stage: combinationally computes every operation other than division and prepares the divider.
// Depends on zalu_pkg.
module zalu_front import zalu_pkg::*; (
  input  logic             valid,
  input  logic [OpW-1:0]   opcode,
  input  logic [WordW-1:0] a,
  input  logic [WordW-1:0] b,
  output zalu_cell_t       slot_out
);
  logic signed [WordW-1:0] sa, sb, inc_v, dec_v;
  logic [WordW-1:0] shl, shr_l, shr_a, sh_res, mag_a, mag_b;
  logic [WordW-1:0] nb;
  logic [3:0] amt;
  logic out_rng, neg_cnt;
  logic [2*WordW-1:0] prod;

  always_comb begin
    sa = a;
    sb = b;
    inc_v = a + 16'd1;
    dec_v = a - 16'd1;
    neg_cnt = b[WordW-1];
    nb = 16'd0 - b;
    out_rng = neg_cnt ? (sb < -16'sd15) : (sb > 16'sd15);
    amt = neg_cnt ? nb[3:0] : b[3:0];
    shl = a << amt;
    shr_l = a >> amt;
    shr_a = WordW'(sa >>> amt);
    prod = a * b;
    mag_a = a[WordW-1] ? 16'd0 - a : a;
    mag_b = b[WordW-1] ? nb : b;
    slot_out = '0;
    slot_out.valid = valid;
    slot_out.op = opcode;
    slot_out.store = 1'b1;
    sh_res = 16'd0;
    unique case (opcode)
      OP_INC: slot_out.res = inc_v;
      OP_DEC: slot_out.res = dec_v;
      OP_NOT: slot_out.res = ~a;
      OP_DEC_CHK: begin
        slot_out.res = dec_v;
        slot_out.br = dec_v < sb;
      end
      OP_INC_CHK: begin
        slot_out.res = inc_v;
        slot_out.br = inc_v > sb;
      end
      OP_TEST: begin
        slot_out.store = 1'b0;
        slot_out.br = (a & b) == b;
      end
      OP_OR:  slot_out.res = a | b;
      OP_AND: slot_out.res = a & b;
      OP_ADD: slot_out.res = a + b;
      OP_SUB: slot_out.res = a - b;
      OP_MUL: slot_out.res = prod[WordW-1:0];
      OP_DIV, OP_MOD: begin
        slot_out.derr = (b == 16'd0);
        slot_out.qneg = a[WordW-1] ^ b[WordW-1];
        slot_out.rneg = a[WordW-1];
        slot_out.quo = mag_a;
        slot_out.dvs = mag_b;
      end
      OP_LSHIFT, OP_ASHIFT: begin
        if (out_rng) begin
          sh_res = (opcode == OP_ASHIFT && a[WordW-1]) ? '1 : '0;
        end else if (!neg_cnt) begin
          sh_res = shl;
        end else begin
          sh_res = (opcode == OP_ASHIFT) ? shr_a : shr_l;
        end
        slot_out.res = sh_res;
      end
      default: slot_out.store = 1'b0;
    endcase
  end
endmodule

// ===== rtl/core/zalu_cell.sv =====
// One restoring-division cell: retires one quotient bit per transaction per cycle while en is high.
// Depends on zalu_pkg.
module zalu_cell import zalu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  zalu_cell_t cell_in,
  output zalu_cell_t cell_out
);
  zalu_cell_t cell_r, cell_nxt;
  logic [WordW:0] trial, diff;

  always_comb begin
    cell_nxt = cell_in;
    trial = {cell_in.rem, cell_in.quo[WordW-1]};
    diff = trial - {1'b0, cell_in.dvs};
    if (!diff[WordW]) begin
      cell_nxt.rem = diff[WordW-1:0];
      cell_nxt.quo = {cell_in.quo[WordW-2:0], 1'b1};
    end else begin
      cell_nxt.rem = trial[WordW-1:0];
      cell_nxt.quo = {cell_in.quo[WordW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (en) begin
      cell_r.op <= cell_nxt.op;
      cell_r.res <= cell_nxt.res;
      cell_r.store <= cell_nxt.store;
      cell_r.br <= cell_nxt.br;
      cell_r.derr <= cell_nxt.derr;
      cell_r.qneg <= cell_nxt.qneg;
      cell_r.rneg <= cell_nxt.rneg;
      cell_r.rem <= cell_nxt.rem;
      cell_r.quo <= cell_nxt.quo;
      cell_r.dvs <= cell_nxt.dvs;
    end
  end

  assign cell_out = cell_r;
endmodule

// ===== rtl/core/zmachine_alu_16bit.sv =====
// Top level of the Z-machine ALU: front stage, chain of division cells, output register.
// Depends on zalu_pkg, zalu_front and zalu_cell.
//  channel | ports                                   | direction
//  in      | in_valid in_ready in_opcode in_operand_a/b | into block
//  out     | out_valid out_ready out_result_word ...   | out of block
// Every transaction passes 16 division cells, one per quotient bit, and then the
// output register; each division cell and the output register is a register stage.
// One transaction is taken per cycle while in_ready is high; the chain advances as a whole.
// A stall on out_ready holds the chain once the output register is full.
// Reset empties the chain and the output register.
module zmachine_alu_16bit import zalu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OpW-1:0]   in_opcode,
  input  logic [WordW-1:0] in_operand_a,
  input  logic [WordW-1:0] in_operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_result_word,
  output logic             out_stores_result,
  output logic             out_branch_taken,
  output logic             out_divide_error
);
  zalu_cell_t chain [WordW+1];
  logic adv;
  logic out_valid_r;
  logic [WordW-1:0] res_r, res_nxt;
  logic store_r, br_r, derr_r;
  zalu_cell_t tail;

  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;

  zalu_front u_front (
    .valid(in_valid), .opcode(in_opcode), .a(in_operand_a), .b(in_operand_b),
    .slot_out(chain[0])
  );

  for (genvar i = 0; i < WordW; i++) begin : g_cell
    zalu_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .cell_in(chain[i]), .cell_out(chain[i+1])
    );
  end

  assign tail = chain[WordW];

  always_comb begin
    res_nxt = tail.res;
    if ((tail.op == OP_DIV || tail.op == OP_MOD) && !tail.derr) begin
      if (tail.op == OP_DIV) begin
        res_nxt = tail.qneg ? 16'd0 - tail.quo : tail.quo;
      end else begin
        res_nxt = tail.rneg ? 16'd0 - tail.rem : tail.rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.valid;
    end
    if (adv) begin
      res_r <= res_nxt;
      store_r <= tail.store;
      br_r <= tail.br;
      derr_r <= tail.derr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_word = res_r;
  assign out_stores_result = store_r;
  assign out_branch_taken = br_r;
  assign out_divide_error = derr_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_word))
    else $error("output changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("ready low with empty output");
  a_derr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |-> out_result_word == 16'd0 && out_stores_result)
    else $error("divide error with nonzero result");
endmodule
